>>> rtl/core/mexp_pkg.sv
// Shared types, constants and rounding helper for the 2x2 matrix exponential core.
package mexp_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 24;
  localparam int PROD_W      = 2 * DATA_W;
  localparam int RND_W       = PROD_W - FRAC_BITS;
  localparam int MAX_TERMS   = 20;
  localparam int TERM_W      = 5;
  localparam int TERMS_RESET = 10;
  localparam int LANES       = 4;

  // Divider: magnitude clamped to DIV_W bits, DIV_BITS quotient bits per cycle
  localparam int DIV_W       = 36;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_BITS    = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [RND_W-1:0]  rnd_t;
  typedef logic [TERM_W-1:0]        term_t;

  localparam elem_t ONE      = elem_t'(64'sd1 << FRAC_BITS);
  localparam elem_t ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam elem_t ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Control from the sequencer to the merge stage
  typedef struct packed {
    logic clear;
    logic accum;
    logic det_mul;
    logic det_sub;
    logic det_fin;
  } mrg_ctl_t;

  // Round a Q(2F) value to Q(F): add half an LSB (saturating at the top), shift right
  function automatic rnd_t round_q(input prod_t x);
    logic signed [PROD_W:0] xs;
    xs = {x[PROD_W-1], x} + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
    if (!xs[PROD_W] && xs[PROD_W-1]) begin
      return {1'b0, {(RND_W-1){1'b1}}};
    end
    return xs[PROD_W-1:FRAC_BITS];
  endfunction

endpackage

>>> rtl/core/mexp_lane.sv
// One element lane: dot product of a term row with a column of A, round, divide by n, saturate.
module mexp_lane (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mexp_pkg::term_t n,
  input  mexp_pkg::elem_t t0,
  input  mexp_pkg::elem_t t1,
  input  mexp_pkg::elem_t a0,
  input  mexp_pkg::elem_t a1,
  output mexp_pkg::elem_t res,
  output logic           sat,
  output logic           done
);
  import mexp_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_SUM  = 3'd1;
  localparam logic [2:0] L_RND  = 3'd2;
  localparam logic [2:0] L_DIV  = 3'd3;
  localparam logic [2:0] L_FIN  = 3'd4;

  localparam logic [DIV_W:0] QLIM_NEG = (DIV_W+1)'(1) << (DATA_W - 1);
  localparam logic [DIV_W:0] QLIM_POS = QLIM_NEG - (DIV_W+1)'(1);
  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [2:0]           st_r, st_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  prod_t                p0_r, p1_r, s_r;
  logic                 neg_r, flg_r, flg_nxt;
  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  term_t                rem_r, rem_nxt;
  elem_t                res_r, res_nxt;

  logic signed [PROD_W:0] sum_w;
  logic                   s_ovf;
  prod_t                  s_sat;
  rnd_t                   rnd_w;
  logic [RND_W-1:0]       mag_w;
  logic [DIV_W-1:0]       mag_clamp;
  logic [DIV_W-1:0]       dvd_div;
  term_t                  rem_div;
  logic                   up_w;
  logic [DIV_W:0]         q_w;
  logic                   q_ovf;
  elem_t                  res_fin;

  // Exact sum of the two products, saturated to 64 bits
  assign sum_w = {p0_r[PROD_W-1], p0_r} + {p1_r[PROD_W-1], p1_r};
  assign s_ovf = sum_w[PROD_W] != sum_w[PROD_W-1];
  assign s_sat = s_ovf ? (sum_w[PROD_W] ? {1'b1, {(PROD_W-1){1'b0}}}
                                        : {1'b0, {(PROD_W-1){1'b1}}})
                       : sum_w[PROD_W-1:0];

  // Round to Q(F), take magnitude; anything past DIV_W bits saturates after the divide anyway
  assign rnd_w     = round_q(s_r);
  assign mag_w     = rnd_w[RND_W-1] ? RND_W'(-rnd_w) : RND_W'(rnd_w);
  assign mag_clamp = (|mag_w[RND_W-1:DIV_W]) ? {DIV_W{1'b1}} : mag_w[DIV_W-1:0];

  // Restoring divide, DIV_BITS quotient bits per cycle; quotient shifts into dvd
  always_comb begin : div_step
    logic [TERM_W:0]  part;
    logic [TERM_W-1:0] rr;
    logic [DIV_W-1:0] dd;
    rr = rem_r;
    dd = dvd_r;
    for (int b = 0; b < DIV_BITS; b++) begin
      part = {rr, dd[DIV_W-1]};
      dd   = {dd[DIV_W-2:0], 1'b0};
      if (part >= {1'b0, n}) begin
        part  = part - {1'b0, n};
        dd[0] = 1'b1;
      end
      rr = part[TERM_W-1:0];
    end
    dvd_div = dd;
    rem_div = rr;
  end

  // Round half away from zero, restore sign, saturate to 32 bits
  assign up_w    = {rem_r, 1'b0} >= {1'b0, n};
  assign q_w     = {1'b0, dvd_r} + (DIV_W+1)'(up_w);
  assign q_ovf   = neg_r ? (q_w > QLIM_NEG) : (q_w > QLIM_POS);
  assign res_fin = q_ovf ? (neg_r ? ELEM_MIN : ELEM_MAX)
                         : (neg_r ? -elem_t'(q_w[DATA_W-1:0]) : elem_t'(q_w[DATA_W-1:0]));

  // Lane sequencer
  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    flg_nxt  = flg_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    unique case (st_r)
      L_IDLE: begin
        if (start) st_nxt = L_SUM;
      end
      L_SUM: begin
        flg_nxt = s_ovf;
        st_nxt  = L_RND;
      end
      L_RND: begin
        dvd_nxt = mag_clamp;
        rem_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = L_DIV;
      end
      L_DIV: begin
        dvd_nxt = dvd_div;
        rem_nxt = rem_div;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) st_nxt = L_FIN;
      end
      L_FIN: begin
        res_nxt  = res_fin;
        flg_nxt  = flg_r | q_ovf;
        done_nxt = 1'b1;
        st_nxt   = L_IDLE;
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      p0_r <= t0 * a0;
      p1_r <= t1 * a1;
    end
    if (st_r == L_SUM) s_r <= s_sat;
    if (st_r == L_RND) neg_r <= rnd_w[RND_W-1];
    cnt_r <= cnt_nxt;
    flg_r <= flg_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    res_r <= res_nxt;
  end

  assign res  = res_r;
  assign sat  = flg_r;
  assign done = done_r;

endmodule

>>> rtl/core/mexp_merge.sv
// Merge stage: accumulates lane terms into E, forms the determinant, holds the result registers.
module mexp_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mexp_pkg::mrg_ctl_t   ctl,
  input  mexp_pkg::elem_t      nt [mexp_pkg::LANES],
  input  logic [mexp_pkg::LANES-1:0] nt_sat,
  output logic                 out_valid,
  output mexp_pkg::elem_t      out_e [mexp_pkg::LANES],
  output mexp_pkg::elem_t      out_det,
  output logic                 out_sat
);
  import mexp_pkg::*;

  elem_t e_r [LANES];
  elem_t e_nxt [LANES];
  logic  flag_r, flag_nxt;
  prod_t pa_r, pb_r, d_r;
  elem_t oe_r [LANES];
  elem_t odet_r;
  logic  osat_r, ovalid_r;

  logic signed [DATA_W:0] acc_w [LANES];
  logic [LANES-1:0]       acc_ovf;
  rnd_t                   det_rnd;
  logic                   det_ovf;
  elem_t                  det_sat;

  // Saturating accumulate of each lane's term
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      acc_w[k]   = {e_r[k][DATA_W-1], e_r[k]} + {nt[k][DATA_W-1], nt[k]};
      acc_ovf[k] = acc_w[k][DATA_W] != acc_w[k][DATA_W-1];
    end
  end

  always_comb begin
    e_nxt    = e_r;
    flag_nxt = flag_r;
    if (ctl.clear) begin
      for (int k = 0; k < LANES; k++) begin
        e_nxt[k] = ((k >> 1) == (k & 1)) ? ONE : '0;
      end
      flag_nxt = 1'b0;
    end else if (ctl.accum) begin
      for (int k = 0; k < LANES; k++) begin
        e_nxt[k] = acc_ovf[k] ? (acc_w[k][DATA_W] ? ELEM_MIN : ELEM_MAX)
                              : acc_w[k][DATA_W-1:0];
      end
      flag_nxt = flag_r | (|acc_ovf) | (|nt_sat);
    end
  end

  // Determinant: round and saturate the difference of products
  assign det_rnd = round_q(d_r);
  assign det_ovf = !((&det_rnd[RND_W-1:DATA_W-1]) || !(|det_rnd[RND_W-1:DATA_W-1]));
  assign det_sat = det_ovf ? (det_rnd[RND_W-1] ? ELEM_MIN : ELEM_MAX)
                           : det_rnd[DATA_W-1:0];

  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    flag_r <= flag_nxt;
    if (ctl.det_mul) begin
      pa_r <= e_r[0] * e_r[3];
      pb_r <= e_r[1] * e_r[2];
    end
    if (ctl.det_sub) d_r <= pa_r - pb_r;
    if (ctl.det_fin) begin
      oe_r   <= e_r;
      odet_r <= det_sat;
      osat_r <= flag_r | det_ovf;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ctl.det_fin;
    end
  end

  assign out_valid = ovalid_r;
  assign out_e     = oe_r;
  assign out_det   = odet_r;
  assign out_sat   = osat_r;

endmodule

>>> rtl/core/matrix_exponential_2x2_taylor_core.sv
// Top level: 2x2 matrix exponential by truncated Taylor series, Q8.24, four element lanes.
// A request is taken when start is high and busy is low. With T = min(series_terms, 20),
// the result shows on the out_ ports for exactly one cycle, marked by out_valid, once T
// series terms and the determinant are done; busy drops in that same cycle, so the next
// request can be taken while the result is on the ports. The receiver cannot stall the
// block and must take the result when out_valid is high. Each series term takes the path
// through a lane: operand multiply, 64-bit sum, round, a restoring divide by n, finish, and
// the merge-stage accumulate. The determinant adds multiply, subtract and round steps.
// series_terms may be written only while busy is low and no result is pending.
module matrix_exponential_2x2_taylor_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  mexp_pkg::elem_t        in_a00,
  input  mexp_pkg::elem_t        in_a01,
  input  mexp_pkg::elem_t        in_a10,
  input  mexp_pkg::elem_t        in_a11,
  input  logic                   cfg_we,
  input  mexp_pkg::term_t        cfg_wdata,
  output logic                   out_valid,
  output mexp_pkg::elem_t        out_e00,
  output mexp_pkg::elem_t        out_e01,
  output mexp_pkg::elem_t        out_e10,
  output mexp_pkg::elem_t        out_e11,
  output mexp_pkg::elem_t        out_det,
  output logic                   out_saturated
);
  import mexp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TERM = 3'd1;
  localparam logic [2:0] S_DMUL = 3'd2;
  localparam logic [2:0] S_DSUB = 3'd3;
  localparam logic [2:0] S_DFIN = 3'd4;

  logic [2:0] state_r, state_nxt;
  term_t      cfg_terms_r;
  term_t      terms_r, terms_nxt;
  term_t      n_r, n_nxt;
  logic       start_r, start_nxt;
  elem_t      a_r [LANES];
  elem_t      a_nxt [LANES];
  elem_t      t_r [LANES];
  elem_t      t_nxt [LANES];
  mrg_ctl_t   ctl;

  term_t            terms_clamp;
  elem_t            nt_w [LANES];
  logic [LANES-1:0] nt_sat_w;
  logic [LANES-1:0] lane_done_w;
  elem_t            oe_w [LANES];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_terms_r <= term_t'(TERMS_RESET);
    end else if (cfg_we) begin
      cfg_terms_r <= cfg_wdata;
    end
  end

  assign terms_clamp = (cfg_terms_r > term_t'(MAX_TERMS)) ? term_t'(MAX_TERMS) : cfg_terms_r;
  assign busy        = state_r != S_IDLE;

  // Term sequencer
  always_comb begin
    state_nxt = state_r;
    terms_nxt = terms_r;
    n_nxt     = n_r;
    start_nxt = 1'b0;
    a_nxt     = a_r;
    t_nxt     = t_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          a_nxt[0] = in_a00;
          a_nxt[1] = in_a01;
          a_nxt[2] = in_a10;
          a_nxt[3] = in_a11;
          for (int k = 0; k < LANES; k++) begin
            t_nxt[k] = ((k >> 1) == (k & 1)) ? ONE : '0;
          end
          n_nxt     = term_t'(1);
          terms_nxt = terms_clamp;
          ctl.clear = 1'b1;
          if (terms_clamp == '0) begin
            state_nxt = S_DMUL;
          end else begin
            start_nxt = 1'b1;
            state_nxt = S_TERM;
          end
        end
      end
      S_TERM: begin
        if (lane_done_w[0]) begin
          t_nxt     = nt_w;
          ctl.accum = 1'b1;
          if (n_r == terms_r) begin
            state_nxt = S_DMUL;
          end else begin
            n_nxt     = n_r + 1'b1;
            start_nxt = 1'b1;
          end
        end
      end
      S_DMUL: begin
        ctl.det_mul = 1'b1;
        state_nxt   = S_DSUB;
      end
      S_DSUB: begin
        ctl.det_sub = 1'b1;
        state_nxt   = S_DFIN;
      end
      S_DFIN: begin
        ctl.det_fin = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    terms_r <= terms_nxt;
    n_r     <= n_nxt;
    a_r     <= a_nxt;
    t_r     <= t_nxt;
  end

  // Element lanes: lane 2*i+j forms row i of the term times column j of A
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    localparam int Row = k / 2;
    localparam int Col = k % 2;
    mexp_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .start (start_r),
      .n     (n_r),
      .t0    (t_r[2*Row]),
      .t1    (t_r[2*Row+1]),
      .a0    (a_r[Col]),
      .a1    (a_r[2+Col]),
      .res   (nt_w[k]),
      .sat   (nt_sat_w[k]),
      .done  (lane_done_w[k])
    );
  end

  mexp_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .nt        (nt_w),
    .nt_sat    (nt_sat_w),
    .out_valid (out_valid),
    .out_e     (oe_w),
    .out_det   (out_det),
    .out_sat   (out_saturated)
  );

  assign out_e00 = oe_w[0];
  assign out_e01 = oe_w[1];
  assign out_e10 = oe_w[2];
  assign out_e11 = oe_w[3];

  // Lanes run in lockstep
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done_w == '0 || lane_done_w == '1)
    else $error("lanes finished out of step");

  // Lane results only arrive while a term is in flight
  a_done_in_term: assert property (@(posedge clk) disable iff (!rst_n)
    |lane_done_w |-> state_r == S_TERM)
    else $error("lane result outside term phase");

  // Term index stays within the configured count
  a_n_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TERM |-> (n_r != '0 && n_r <= terms_r))
    else $error("term index out of range");

  // Result strobe follows the determinant finish step
  a_valid_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DFIN))
    else $error("result strobe without determinant finish");

endmodule

>>> test/matrix_exponential_2x2_taylor_core_test.sv
// Testbench for the 2x2 Taylor-series matrix exponential core, self-checking.
`timescale 1ns / 1ps

localparam int              FRAC     = 24;
localparam int              TERM_CAP = 20;
localparam longint          HALF_LSB = 64'sd1 << (FRAC - 1);
localparam longint          L_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
localparam longint          L_MIN    = 64'sh8000_0000_0000_0000;
localparam longint          W_MAX    = 64'sd2147483647;
localparam longint          W_MIN    = -64'sd2147483648;
localparam mexp_pkg::elem_t Q_ONE    = 32'sh0100_0000;
localparam mexp_pkg::elem_t Q_MAX    = 32'sh7FFF_FFFF;
localparam mexp_pkg::elem_t Q_MIN    = 32'sh8000_0000;

typedef struct {
  mexp_pkg::elem_t e00;
  mexp_pkg::elem_t e01;
  mexp_pkg::elem_t e10;
  mexp_pkg::elem_t e11;
  mexp_pkg::elem_t det;
  logic            sat;
} mexp_result_t;

// Predicts the exponential of each request and checks results in order
class mexp_scoreboard;
  mexp_result_t    pending_q[$];
  mexp_pkg::term_t series_terms;
  bit              sat_seen;
  int              failures;

  function new();
    series_terms = 5'd10;
    failures = 0;
  endfunction

  function void set_terms(mexp_pkg::term_t v);
    series_terms = v;
  endfunction

  function int pending();
    return pending_q.size();
  endfunction

  function longint sat_add64(longint x, longint y);
    longint s;
    s = x + y;
    if (x[63] == y[63] && s[63] != x[63]) begin
      sat_seen = 1;
      return x[63] ? L_MIN : L_MAX;
    end
    return s;
  endfunction

  // Q(2F) -> Q(F), round half up, top clamped
  function longint round_fix(longint x);
    if (x > L_MAX - HALF_LSB) x = L_MAX;
    else x = x + HALF_LSB;
    return x >>> FRAC;
  endfunction

  // divide, nearest, ties away from zero
  function longint div_near(longint x, int n);
    longint unsigned mag, q, r, d;
    d = longint'(n);
    mag = (x < 0) ? longint'(-x) : longint'(x);
    q = mag / d;
    r = mag % d;
    if (r >= d - r) q = q + 1;
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  function longint sat_word(longint x);
    if (x > W_MAX) begin
      sat_seen = 1;
      return W_MAX;
    end
    if (x < W_MIN) begin
      sat_seen = 1;
      return W_MIN;
    end
    return x;
  endfunction

  function void note_request(mexp_pkg::elem_t a00, mexp_pkg::elem_t a01,
                             mexp_pkg::elem_t a10, mexp_pkg::elem_t a11);
    longint       a[2][2];
    longint       t[2][2];
    longint       e[2][2];
    longint       nt[2][2];
    longint       d;
    int           n_terms;
    mexp_result_t r;
    sat_seen = 0;
    n_terms = (series_terms > TERM_CAP) ? TERM_CAP : int'(series_terms);
    a[0][0] = a00;
    a[0][1] = a01;
    a[1][0] = a10;
    a[1][1] = a11;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        e[i][j] = (i == j) ? (64'sd1 << FRAC) : 64'sd0;
        t[i][j] = e[i][j];
      end
    end
    // each term = previous term * A / n, then accumulated
    for (int n = 1; n <= n_terms; n++) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          nt[i][j] = sat_word(div_near(round_fix(
                       sat_add64(t[i][0] * a[0][j], t[i][1] * a[1][j])), n));
        end
      end
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          t[i][j] = nt[i][j];
          e[i][j] = sat_word(e[i][j] + t[i][j]);
        end
      end
    end
    d = e[0][0] * e[1][1] - e[0][1] * e[1][0];
    r.det = mexp_pkg::elem_t'(sat_word(round_fix(d)));
    r.e00 = mexp_pkg::elem_t'(e[0][0]);
    r.e01 = mexp_pkg::elem_t'(e[0][1]);
    r.e10 = mexp_pkg::elem_t'(e[1][0]);
    r.e11 = mexp_pkg::elem_t'(e[1][1]);
    r.sat = sat_seen;
    pending_q.push_back(r);
  endfunction

  function void check_result(mexp_result_t got);
    mexp_result_t want;
    if (pending_q.size() == 0) begin
      if (failures < 10)
        $display("ERROR: result with no request outstanding: e=%h %h %h %h det=%h sat=%b",
                 got.e00, got.e01, got.e10, got.e11, got.det, got.sat);
      failures++;
      return;
    end
    want = pending_q.pop_front();
    if (got.e00 !== want.e00 || got.e01 !== want.e01 || got.e10 !== want.e10 ||
        got.e11 !== want.e11 || got.det !== want.det || got.sat !== want.sat) begin
      if (failures < 10) begin
        $display("ERROR: exp e=%h %h %h %h det=%h sat=%b",
                 want.e00, want.e01, want.e10, want.e11, want.det, want.sat);
        $display("       got e=%h %h %h %h det=%h sat=%b",
                 got.e00, got.e01, got.e10, got.e11, got.det, got.sat);
      end
      failures++;
    end
  endfunction
endclass

module matrix_exponential_2x2_taylor_core_test;
  import mexp_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 200;
  localparam int PHASES      = 13;
  localparam int PHASE_ITEMS = 50;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  elem_t in_a00, in_a01, in_a10, in_a11;
  logic  cfg_we;
  term_t cfg_wdata;
  logic  out_valid;
  elem_t out_e00, out_e01, out_e10, out_e11, out_det;
  logic  out_saturated;

  mexp_scoreboard sb;
  int             req_count = 0;
  int             idle_cycles;

  matrix_exponential_2x2_taylor_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_a00       (in_a00),
    .in_a01       (in_a01),
    .in_a10       (in_a10),
    .in_a11       (in_a11),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_e00      (out_e00),
    .out_e01      (out_e01),
    .out_e10      (out_e10),
    .out_e11      (out_e11),
    .out_det      (out_det),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor: register writes, results, accepted requests, watchdog
  always @(posedge clk) begin
    mexp_result_t got;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (cfg_we) sb.set_terms(cfg_wdata);
      if (out_valid) begin
        got.e00 = out_e00;
        got.e01 = out_e01;
        got.e10 = out_e10;
        got.e11 = out_e11;
        got.det = out_det;
        got.sat = out_saturated;
        sb.check_result(got);
      end
      if (start && !busy) begin
        sb.note_request(in_a00, in_a01, in_a10, in_a11);
        req_count <= req_count + 1;
      end
      if (out_valid || cfg_we || (start && !busy)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Drive one request and hold it until taken; called at a falling edge
  task automatic send_matrix(elem_t a00, elem_t a01, elem_t a10, elem_t a11);
    int target;
    target = req_count + 1;
    start  <= 1'b1;
    in_a00 <= a00;
    in_a01 <= a01;
    in_a10 <= a10;
    in_a11 <= a11;
    @(negedge clk);
    while (req_count < target) @(negedge clk);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Register write only once the block has drained
  task automatic set_series_terms(term_t v);
    start <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0 || busy) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic elem_t rand_elem();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return elem_t'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    if (pick < 60) return elem_t'(int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
    if (pick < 75) return elem_t'(int'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
    if (pick < 90) return elem_t'($urandom);
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return Q_ONE;
      2:       return -Q_ONE;
      3:       return Q_MAX;
      default: return Q_MIN;
    endcase
  endfunction

  // Stimulus
  initial begin
    elem_t b00, b01, b10, b11;
    bit    steady;
    term_t terms;
    sb        = new();
    rst_n     = 1'b0;
    start     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_a00    = '0;
    in_a01    = '0;
    in_a10    = '0;
    in_a11    = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, at the reset term count
    send_matrix('0, '0, '0, '0);
    send_matrix(Q_ONE, '0, '0, Q_ONE);
    send_matrix(-Q_ONE, '0, '0, -Q_ONE);
    send_matrix('0, Q_ONE, '0, '0);
    send_matrix('0, -Q_ONE, Q_ONE, '0);
    idle_gap(2);
    send_matrix(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_matrix(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_matrix(Q_MAX, Q_MIN, Q_MIN, Q_MAX);
    send_matrix(32'sh0000_0001, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'sh0000_0001);
    // zero terms: identity and unit determinant whatever the input
    set_series_terms(5'd0);
    send_matrix(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    send_matrix(32'sh0180_0000, 32'shFF40_0000, 32'sh0020_0000, 32'sh0300_0000);
    // beyond the cap, clamped to twenty
    set_series_terms(5'd31);
    send_matrix(32'sh0200_0000, '0, '0, 32'shFE00_0000);
    send_matrix(32'sh0080_0000, 32'sh0100_0000, 32'shFF00_0000, 32'sh0080_0000);
    send_matrix(Q_MIN, '0, '0, Q_MIN);
    set_series_terms(5'd20);
    send_matrix(32'sh0200_0000, '0, '0, 32'shFE00_0000);
    send_matrix(32'sh0400_0000, 32'sh0400_0000, 32'sh0400_0000, 32'sh0400_0000);
    send_matrix(Q_MAX, '0, '0, Q_MAX);
    set_series_terms(5'd1);
    send_matrix(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    send_matrix(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send_matrix(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001);
    send_matrix(32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0002);

    // random phases, each at its own term count
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       terms = 5'd20;
        1:       terms = 5'd0;
        2:       terms = 5'd31;
        3:       terms = 5'd2;
        default: terms = term_t'($urandom_range(0, 31));
      endcase
      set_series_terms(terms);
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        b00 = rand_elem();
        b01 = rand_elem();
        b10 = rand_elem();
        b11 = rand_elem();
        case ($urandom_range(0, 9))
          0: begin
            b01 = '0;
            b10 = '0;
          end
          1:       b10 = '0;
          default: ;
        endcase
        send_matrix(b00, b01, b10, b11);
        if (!steady) idle_gap(gap_len());
      end
    end

    // drain, then settle
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
